### design/md4_pkg.sv
`default_nettype none
package md4_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [31:0] K_ROUND2 = 32'h5A827999;
	localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_STEP = 6'd47;

	localparam logic [1:0] ROUND_F = 2'd0;
	localparam logic [1:0] ROUND_G = 2'd1;
	localparam logic [1:0] ROUND_H = 2'd2;

	function automatic logic [3:0] word_sel(input logic [5:0] step);
		logic [3:0] s;
		begin
			s = step[3:0];
			case (step[5:4])
				ROUND_G: word_sel = {s[1:0], s[3:2]};
				ROUND_H: word_sel = {s[0], s[1], s[2], s[3]};
				default: word_sel = s;
			endcase
		end
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] step);
		logic [4:0] r;
		begin
			r = 5'd3;
			case (step[5:4])
				ROUND_F: begin
					case (step[1:0])
						2'd0: r = 5'd3;
						2'd1: r = 5'd7;
						2'd2: r = 5'd11;
						default: r = 5'd19;
					endcase
				end
				ROUND_G: begin
					case (step[1:0])
						2'd0: r = 5'd3;
						2'd1: r = 5'd5;
						2'd2: r = 5'd9;
						default: r = 5'd13;
					endcase
				end
				default: begin
					case (step[1:0])
						2'd0: r = 5'd3;
						2'd1: r = 5'd9;
						2'd2: r = 5'd11;
						default: r = 5'd15;
					endcase
				end
			endcase
			rot_amt = r;
		end
	endfunction

endpackage
`default_nettype wire

### design/md4_hash_engine_unit.sv
`default_nettype none
// A message word is written while idle; a word that fills a 64-byte block keeps the unit busy
// (load, 48 steps of the single round unit, chaining add) before the next word is taken.
// A finish word writes padding bytes one at a time, 9 to 72 bytes, plus one or two
// compressions, then offers the four digest words, one per cycle when taken at once.
// Reset (arst_n low) loads the initial chaining words and clears the byte count;
// the block buffer is undefined until written.
module md4_hash_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        mode,
	input  wire logic [7:0]  data_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             last_word
);
	import md4_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LEN,
		S_LOAD,
		S_RUN,
		S_ADD,
		S_EMIT
	} state_t;

	state_t      state_q;
	state_t      ret_q;
	logic [31:0] chain_q [4];
	logic [63:0] count_q;
	logic [63:0] len_q;
	logic        mark_q;
	logic [5:0]  step_q;
	logic [1:0]  idx_q;
	logic        result_valid_q;
	logic [31:0] a_q, b_q, c_q, d_q, w_q;
	logic [31:0] mem_q [16];

	logic [5:0]  pos;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic [3:0]  rd_addr;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] sum;
	logic [63:0] rot_wide;
	logic [31:0] step_out;

	assign pos = count_q[5:0];
	assign item_ready = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign digest_word = chain_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 2'd3);

	always_comb begin
		wr_en = 1'b0;
		wr_byte = data_byte;
		unique case (state_q)
			S_IDLE: wr_en = item_valid && !mode;
			S_PAD: begin
				wr_en = mark_q || (pos != LEN_POS);
				wr_byte = mark_q ? PAD_MARK : 8'h00;
			end
			S_LEN: begin
				wr_en = 1'b1;
				wr_byte = len_q[{pos[2:0], 3'b000} +: 8];
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign rd_addr = (state_q == S_LOAD) ? word_sel(6'd0) : word_sel(step_q + 6'd1);

	always_comb begin
		case (step_q[5:4])
			ROUND_F: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = 32'h0;
			end
			ROUND_G: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = K_ROUND2;
			end
			default: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = K_ROUND3;
			end
		endcase
	end

	assign sum = a_q + f_val + w_q + k_val;
	assign rot_wide = {sum, sum} << rot_amt(step_q);
	assign step_out = rot_wide[63:32];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
		end
		w_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid && mode) begin
			len_q <= {count_q[60:0], 3'b000};
		end
		if (state_q == S_LOAD) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (state_q == S_RUN) begin
			a_q <= d_q;
			b_q <= step_out;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
			count_q <= 64'd0;
			mark_q <= 1'b0;
			step_q <= 6'd0;
			idx_q <= 2'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + 64'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (mode) begin
							mark_q <= 1'b1;
							state_q <= S_PAD;
						end else if (pos == LAST_POS) begin
							ret_q <= S_IDLE;
							state_q <= S_LOAD;
						end
					end
				end
				S_PAD: begin
					mark_q <= 1'b0;
					if (!mark_q && pos == LEN_POS) begin
						state_q <= S_LEN;
					end else if (pos == LAST_POS) begin
						ret_q <= S_PAD;
						state_q <= S_LOAD;
					end
				end
				S_LEN: begin
					if (pos == LAST_POS) begin
						ret_q <= S_EMIT;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					step_q <= 6'd0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					step_q <= step_q + 6'd1;
					if (step_q == LAST_STEP) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					state_q <= ret_q;
					if (ret_q == S_EMIT) begin
						idx_q <= 2'd0;
						result_valid_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (result_ready) begin
						if (idx_q == 2'd3) begin
							result_valid_q <= 1'b0;
							chain_q[0] <= INIT_A;
							chain_q[1] <= INIT_B;
							chain_q[2] <= INIT_C;
							chain_q[3] <= INIT_D;
							count_q <= 64'd0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### tb/sv/md4_hash_engine_unit_tb.sv
`timescale 1ns / 1ps

module md4_hash_engine_unit_tb;
	import md4_pkg::*;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_FINISH = 1'b1;
	localparam int WORD_TARGET = 410;

	localparam int unsigned MSG_ORDER [48] = '{
		0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
		0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
		0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15
	};
	localparam int unsigned ROT_LEFT [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
	localparam int unsigned EDGE_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_t;

	class md4_digest_book;
		logic [31:0] chain [4];
		logic [7:0]  blk [64];
		logic [63:0] nbytes;
		digest_t     due_digest [$];
		int          errors;

		function new();
			errors = 0;
			foreach (blk[i]) blk[i] = 8'h00;
			restart();
		endfunction

		function void restart();
			chain[0] = INIT_A;
			chain[1] = INIT_B;
			chain[2] = INIT_C;
			chain[3] = INIT_D;
			nbytes = 64'd0;
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] a, b, c, d, f, k, s;
			int unsigned rnd, r;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4 * i + 3], blk[4 * i + 2], blk[4 * i + 1], blk[4 * i]};
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (int i = 0; i < 48; i++) begin
				rnd = i / 16;
				case (rnd)
					0: begin
						f = (b & c) | (~b & d);
						k = 32'd0;
					end
					1: begin
						f = (b & c) | (b & d) | (c & d);
						k = K_ROUND2;
					end
					default: begin
						f = b ^ c ^ d;
						k = K_ROUND3;
					end
				endcase
				s = a + f + w[MSG_ORDER[i]] + k;
				r = ROT_LEFT[rnd * 4 + i % 4];
				a = d;
				d = c;
				c = b;
				b = (s << r) | (s >> (32 - r));
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		function void absorb_byte(input logic [7:0] v);
			blk[nbytes[5:0]] = v;
			nbytes++;
			if (nbytes[5:0] == 6'd0)
				compress();
		endfunction

		function void take_word(input logic m, input logic [7:0] v);
			logic [63:0] bits;
			digest_t e;
			if (m == MODE_BYTE) begin
				absorb_byte(v);
				return;
			end
			bits = nbytes << 3;
			absorb_byte(PAD_MARK);
			while (nbytes[5:0] != LEN_POS)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(bits[8 * i +: 8]);
			for (int i = 0; i < 4; i++) begin
				e.word = chain[i];
				e.idx = 2'(i);
				e.last = (i == 3);
				due_digest.push_back(e);
			end
			restart();
		endfunction

		function void check_digest(input logic [31:0] w, input logic [1:0] idx,
				input logic last);
			digest_t e;
			if (due_digest.size() == 0) begin
				$display("%0t: unexpected digest word %h index %0d last %0b",
					$realtime, w, idx, last);
				errors++;
				return;
			end
			e = due_digest.pop_front();
			if (w !== e.word) begin
				$display("%0t: digest_word expected %h actual %h", $realtime, e.word, w);
				errors++;
			end
			if (idx !== e.idx) begin
				$display("%0t: word_index expected %0d actual %0d", $realtime, e.idx, idx);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_word expected %0b actual %0b", $realtime, e.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return due_digest.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	logic       mode;
	logic [7:0] data_byte;
	logic       result_valid;
	logic       result_ready;
	logic [31:0] digest_word;
	logic [1:0] word_index;
	logic       last_word;

	md4_digest_book book = new();
	int words_sent = 0;
	bit send_calm = 1'b0;

	md4_hash_engine_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode(mode),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_word(input logic m, input logic [7:0] v);
		int g;
		g = pick_gap(send_calm);
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		data_byte <= v;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		book.take_word(m, v);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_word(MODE_BYTE, 8'($urandom_range(0, 255)));
		send_word(MODE_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained(input int cap);
		int n;
		n = 0;
		while (book.pending() != 0 && n < cap) begin
			@(negedge clk);
			n++;
		end
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		item_valid = 1'b0;
		mode = MODE_BYTE;
		data_byte = 8'h00;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(MODE_FINISH, 8'hA5);
		send_word(MODE_BYTE, 8'h61);
		send_word(MODE_BYTE, 8'h62);
		send_word(MODE_BYTE, 8'h63);
		send_word(MODE_FINISH, 8'h5A);
		send_word(MODE_BYTE, 8'h00);
		send_word(MODE_FINISH, 8'h00);
		send_word(MODE_BYTE, 8'hFF);
		send_word(MODE_FINISH, 8'hFF);
		send_word(MODE_FINISH, 8'hFF);
		send_word(MODE_FINISH, 8'h00);
		send_word(MODE_BYTE, 8'h80);
		send_word(MODE_BYTE, 8'h7F);
		send_word(MODE_FINISH, 8'h3C);

		// hold off until every digest word is back or the wait gives up
		item_valid <= 1'b0;
		wait_drained(20000);
		@(negedge clk);

		while (words_sent < WORD_TARGET) begin
			send_calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 2)
				len = EDGE_LEN[$urandom_range(0, 9)];
			else
				len = $urandom_range(0, 24);
			if (len > WORD_TARGET - words_sent - 1)
				len = WORD_TARGET - words_sent - 1;
			send_message(len);
			if ($urandom_range(0, 7) == 0) begin
				item_valid <= 1'b0;
				wait_drained(20000);
				@(negedge clk);
			end
		end

		item_valid <= 1'b0;
		wait_drained(20000);
		repeat (120) @(negedge clk);
		if (book.pending() != 0) begin
			$display("%0t: %0d digest words never arrived", $realtime, book.pending());
			book.errors++;
		end
		if (book.errors == 0)
			$display("** md4_hash_engine_unit: PASSED **");
		else
			$display("** md4_hash_engine_unit: FAILED **");
		$finish;
	end

	initial begin
		int stall;
		bit calm;
		result_ready = 1'b0;
		stall = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				calm = !calm;
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
				stall = pick_gap(calm);
			end
			@(posedge clk);
			if (arst_n && result_valid && result_ready)
				book.check_digest(digest_word, word_index, last_word);
		end
	end

	initial begin
		#5_000_000;
		$display("** md4_hash_engine_unit: FAILED **");
		$finish;
	end

endmodule

### sim.f
design/md4_pkg.sv
design/md4_hash_engine_unit.sv
tb/sv/md4_hash_engine_unit_tb.sv
